// File: sv/cbc_pkg.sv
// ----------------------------------------------------------------------------
// cbc_pkg
// Shared types and constants for the color blob centroid block: register
// indexes, reset values, field widths and the configuration bundle.
// ----------------------------------------------------------------------------
package cbc_pkg;

   localparam int BOUND_W   = 24;
   localparam int SIZE_W    = 12;
   localparam int CHAN_W    = 8;
   localparam int CENTER_W  = 11;
   localparam int MATCH_W   = 23;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 24;

   localparam logic [CSR_IDX_W-1:0] CSR_LOWER_BOUND = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_UPPER_BOUND = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LEFT_HALF   = 3'd4;

   localparam logic [BOUND_W-1:0] LOWER_RESET  = 24'h0F9AF5;
   localparam logic [BOUND_W-1:0] UPPER_RESET  = 24'h41FFFF;
   localparam logic [SIZE_W-1:0]  WIDTH_RESET  = 12'd640;
   localparam logic [SIZE_W-1:0]  HEIGHT_RESET = 12'd480;

   typedef struct packed {
      logic [BOUND_W-1:0] lower_bgr;
      logic [BOUND_W-1:0] upper_bgr;
      logic [SIZE_W-1:0]  frame_width;
      logic [SIZE_W-1:0]  frame_height;
      logic               left_half_only;
   } cfg_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

endpackage

// File: sv/color_blob_centroid.sv
// ----------------------------------------------------------------------------
// color_blob_centroid
// Color threshold and centroid over a raster pixel stream: one result per
// frame with the floored mean row and column of matching pixels.
//
//   channel  direction  ports                       content
//   req      in         req_tvalid/tready/tdata     one BGR pixel, raster order
//   rsp      out        rsp_tvalid/tready/tdata/    one centroid per frame
//                       tuser
//   csr      in         csr_we/index/wdata          register write, no wait
//
// Pixels are taken one per cycle unless the input stalls. A frame's totals go
// into a two-entry queue; the divider works through them one quotient bit at a
// time and then holds the result until it is taken. The input stalls only on a
// frame-end pixel while both queue entries are full. On reset, registers take
// their defaults and the queue and the front-end counters and sums clear.
// ----------------------------------------------------------------------------
module color_blob_centroid #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // blue [7:0], green [15:8], red [23:16]
   input  logic [23:0]                       req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // center_row [10:0], center_col [21:11], match_count [44:22], zero fill
   output logic [47:0]                       rsp_tdata,
   // found [0]
   output logic                              rsp_tuser,
   input  logic                              csr_we,
   input  logic [cbc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [cbc_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import cbc_pkg::*;

   // size registers are 12 bits, so no frame exceeds 4095 either way
   localparam int W_LIM = (MAX_WIDTH  < 4095) ? MAX_WIDTH  : 4095;
   localparam int H_LIM = (MAX_HEIGHT < 4095) ? MAX_HEIGHT : 4095;
   localparam int COL_W = $clog2(W_LIM);
   localparam int ROW_W = $clog2(H_LIM);
   localparam int Q_W   = (COL_W > ROW_W) ? COL_W : ROW_W;
   localparam int HIT_W = $clog2(W_LIM * H_LIM + 1);
   localparam int SUM_W = Q_W + HIT_W;
   localparam int ENTRY_W = HIT_W + 2 * SUM_W;

   cfg_type            cfg_ff;
   queue_status_type   queue_status;
   logic               push, pop;
   logic [HIT_W-1:0]   push_hits, head_hits, hits;
   logic [SUM_W-1:0]   push_row_sum, push_col_sum, head_row_sum, head_col_sum;
   logic [ENTRY_W-1:0] push_entry, head_entry;
   logic [Q_W-1:0]     quot_row, quot_col;
   logic               found;
   logic [Q_W+CENTER_W-1:0]   row_ext, col_ext;
   logic [HIT_W+MATCH_W-1:0]  hits_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.lower_bgr      <= LOWER_RESET;
         cfg_ff.upper_bgr      <= UPPER_RESET;
         cfg_ff.frame_width    <= WIDTH_RESET;
         cfg_ff.frame_height   <= HEIGHT_RESET;
         cfg_ff.left_half_only <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_LOWER_BOUND:  cfg_ff.lower_bgr      <= csr_wdata[BOUND_W-1:0];
            CSR_UPPER_BOUND:  cfg_ff.upper_bgr      <= csr_wdata[BOUND_W-1:0];
            CSR_FRAME_WIDTH:  cfg_ff.frame_width    <= csr_wdata[SIZE_W-1:0];
            CSR_FRAME_HEIGHT: cfg_ff.frame_height   <= csr_wdata[SIZE_W-1:0];
            CSR_LEFT_HALF:    cfg_ff.left_half_only <= csr_wdata[0];
            default: begin
               // drop writes to unknown indexes
            end
         endcase
      end
   end

   cbc_front #(
      .W_LIM (W_LIM),
      .H_LIM (H_LIM),
      .COL_W (COL_W),
      .ROW_W (ROW_W),
      .HIT_W (HIT_W),
      .SUM_W (SUM_W)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .blue         (req_tdata[7:0]),
      .green        (req_tdata[15:8]),
      .red          (req_tdata[23:16]),
      .queue_status (queue_status),
      .push         (push),
      .push_hits    (push_hits),
      .push_row_sum (push_row_sum),
      .push_col_sum (push_col_sum)
   );

   assign push_entry = {push_hits, push_row_sum, push_col_sum};

   cbc_queue #(
      .DATA_W (ENTRY_W),
      .DEPTH  (2)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_entry),
      .pop       (pop),
      .head_data (head_entry),
      .status    (queue_status)
   );

   assign head_hits    = head_entry[ENTRY_W-1 -: HIT_W];
   assign head_row_sum = head_entry[2*SUM_W-1 -: SUM_W];
   assign head_col_sum = head_entry[SUM_W-1:0];

   cbc_div #(
      .Q_W   (Q_W),
      .HIT_W (HIT_W),
      .SUM_W (SUM_W)
   ) u_div (
      .clock        (clock),
      .reset        (reset),
      .queue_status (queue_status),
      .head_hits    (head_hits),
      .head_row_sum (head_row_sum),
      .head_col_sum (head_col_sum),
      .pop          (pop),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .found        (found),
      .quot_row     (quot_row),
      .quot_col     (quot_col),
      .hits         (hits)
   );

   // fit quotients and count to the result field widths
   assign row_ext  = {{CENTER_W{1'b0}}, quot_row};
   assign col_ext  = {{CENTER_W{1'b0}}, quot_col};
   assign hits_ext = {{MATCH_W{1'b0}}, hits};

   assign rsp_tdata = {3'b000, hits_ext[MATCH_W-1:0], col_ext[CENTER_W-1:0],
                       row_ext[CENTER_W-1:0]};
   assign rsp_tuser = found;

endmodule

// File: sv/cbc_queue.sv
// ----------------------------------------------------------------------------
// cbc_queue
// Short first-in first-out queue of finished frame totals between the pixel
// front end and the divider back end.
// ----------------------------------------------------------------------------
module cbc_queue #(
   parameter int DATA_W = 80,
   parameter int DEPTH  = 2
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  logic [DATA_W-1:0]           push_data,
   input  logic                        pop,
   output logic [DATA_W-1:0]           head_data,
   output cbc_pkg::queue_status_type   status
);
   import cbc_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_data    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: sv/cbc_front.sv
// ----------------------------------------------------------------------------
// cbc_front
// Pixel front end: tracks raster position, tests each pixel against the
// color bounds and accumulates hit count and row and column sums. At the
// last pixel of a frame it pushes the totals to the queue and clears.
// ----------------------------------------------------------------------------
module cbc_front #(
   parameter int W_LIM = 2048,
   parameter int H_LIM = 2048,
   parameter int COL_W = 11,
   parameter int ROW_W = 11,
   parameter int HIT_W = 23,
   parameter int SUM_W = 34
) (
   input  logic                               clock,
   input  logic                               reset,
   input  cbc_pkg::cfg_type                   cfg,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [cbc_pkg::CHAN_W-1:0]         blue,
   input  logic [cbc_pkg::CHAN_W-1:0]         green,
   input  logic [cbc_pkg::CHAN_W-1:0]         red,
   input  cbc_pkg::queue_status_type          queue_status,
   output logic                               push,
   output logic [HIT_W-1:0]                   push_hits,
   output logic [SUM_W-1:0]                   push_row_sum,
   output logic [SUM_W-1:0]                   push_col_sum
);
   import cbc_pkg::*;

   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [HIT_W-1:0]  hits_ff, hits_in, hits_next;
   logic [SUM_W-1:0]  row_sum_ff, row_sum_in, row_sum_next;
   logic [SUM_W-1:0]  col_sum_ff, col_sum_in, col_sum_next;
   logic [SIZE_W-1:0] w_eff, h_eff;
   logic [SIZE_W:0]   col_plus, row_plus;
   logic              row_end, frame_end, accept, match, col_past_half, hit;

   // clamp the frame size to 1..limit
   always_comb begin
      if (cfg.frame_width == '0) begin
         w_eff = SIZE_W'(1);
      end else if ({1'b0, cfg.frame_width} > (SIZE_W + 1)'(W_LIM)) begin
         w_eff = SIZE_W'(W_LIM);
      end else begin
         w_eff = cfg.frame_width;
      end
      if (cfg.frame_height == '0) begin
         h_eff = SIZE_W'(1);
      end else if ({1'b0, cfg.frame_height} > (SIZE_W + 1)'(H_LIM)) begin
         h_eff = SIZE_W'(H_LIM);
      end else begin
         h_eff = cfg.frame_height;
      end
   end

   assign col_plus  = (SIZE_W + 1)'(col_ff) + 1'b1;
   assign row_plus  = (SIZE_W + 1)'(row_ff) + 1'b1;
   assign row_end   = (col_plus >= {1'b0, w_eff});
   assign frame_end = row_end && (row_plus >= {1'b0, h_eff});

   assign match = (blue  >= cfg.lower_bgr[23:16]) && (blue  <= cfg.upper_bgr[23:16]) &&
                  (green >= cfg.lower_bgr[15:8])  && (green <= cfg.upper_bgr[15:8])  &&
                  (red   >= cfg.lower_bgr[7:0])   && (red   <= cfg.upper_bgr[7:0]);
   assign col_past_half = (SIZE_W'(col_ff) > (w_eff >> 1));
   assign hit = match && !(cfg.left_half_only && col_past_half);

   // stall only a frame-end pixel whose totals have no queue slot
   assign req_tready = !(frame_end && queue_status.full);
   assign accept     = req_tvalid && req_tready;

   assign hits_next    = hit ? hits_ff + 1'b1 : hits_ff;
   assign row_sum_next = hit ? row_sum_ff + SUM_W'(row_ff) : row_sum_ff;
   assign col_sum_next = hit ? col_sum_ff + SUM_W'(col_ff) : col_sum_ff;

   assign push         = accept && frame_end;
   assign push_hits    = hits_next;
   assign push_row_sum = row_sum_next;
   assign push_col_sum = col_sum_next;

   always_comb begin
      col_in     = col_ff;
      row_in     = row_ff;
      hits_in    = hits_ff;
      row_sum_in = row_sum_ff;
      col_sum_in = col_sum_ff;
      if (accept) begin
         priority if (frame_end) begin
            col_in     = '0;
            row_in     = '0;
            hits_in    = '0;
            row_sum_in = '0;
            col_sum_in = '0;
         end else if (row_end) begin
            col_in     = '0;
            row_in     = row_ff + 1'b1;
            hits_in    = hits_next;
            row_sum_in = row_sum_next;
            col_sum_in = col_sum_next;
         end else begin
            col_in     = col_ff + 1'b1;
            hits_in    = hits_next;
            row_sum_in = row_sum_next;
            col_sum_in = col_sum_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         hits_ff    <= '0;
         row_sum_ff <= '0;
         col_sum_ff <= '0;
      end else begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         hits_ff    <= hits_in;
         row_sum_ff <= row_sum_in;
         col_sum_ff <= col_sum_in;
      end
   end

endmodule

// File: sv/cbc_div.sv
// ----------------------------------------------------------------------------
// cbc_div
// Divider back end: takes one set of frame totals from the queue, runs two
// restoring divisions side by side (row sum and column sum by hit count),
// one quotient bit per cycle (skipped when the hit count is zero), and holds the result until it is taken.
// ----------------------------------------------------------------------------
module cbc_div #(
   parameter int Q_W   = 11,
   parameter int HIT_W = 23,
   parameter int SUM_W = 34
) (
   input  logic                        clock,
   input  logic                        reset,
   input  cbc_pkg::queue_status_type   queue_status,
   input  logic [HIT_W-1:0]            head_hits,
   input  logic [SUM_W-1:0]            head_row_sum,
   input  logic [SUM_W-1:0]            head_col_sum,
   output logic                        pop,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic                        found,
   output logic [Q_W-1:0]              quot_row,
   output logic [Q_W-1:0]              quot_col,
   output logic [HIT_W-1:0]            hits
);
   import cbc_pkg::*;

   localparam int STEP_W = (Q_W > 1) ? $clog2(Q_W) : 1;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_OUT  = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [SUM_W-1:0]  rem_row_ff, rem_row_in;
   logic [SUM_W-1:0]  rem_col_ff, rem_col_in;
   logic [SUM_W-1:0]  dsh_ff, dsh_in;
   logic [Q_W-1:0]    q_row_ff, q_row_in;
   logic [Q_W-1:0]    q_col_ff, q_col_in;
   logic [HIT_W-1:0]  hits_ff, hits_in;
   logic              found_ff, found_in;
   logic              ge_row, ge_col;

   assign pop        = (state_ff == ST_IDLE) && !queue_status.empty;
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign found      = found_ff;
   assign quot_row   = q_row_ff;
   assign quot_col   = q_col_ff;
   assign hits       = hits_ff;

   assign ge_row = (rem_row_ff >= dsh_ff);
   assign ge_col = (rem_col_ff >= dsh_ff);

   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      rem_row_in = rem_row_ff;
      rem_col_in = rem_col_ff;
      dsh_in     = dsh_ff;
      q_row_in   = q_row_ff;
      q_col_in   = q_col_ff;
      hits_in    = hits_ff;
      found_in   = found_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               hits_in    = head_hits;
               q_row_in   = '0;
               q_col_in   = '0;
               rem_row_in = head_row_sum;
               rem_col_in = head_col_sum;
               // quotient fits Q_W bits, so start at the top quotient bit
               dsh_in     = SUM_W'(head_hits) << (Q_W - 1);
               step_in    = STEP_W'(Q_W - 1);
               if (head_hits == '0) begin
                  found_in = 1'b0;
                  state_in = ST_OUT;
               end else begin
                  found_in = 1'b1;
                  state_in = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            rem_row_in = ge_row ? rem_row_ff - dsh_ff : rem_row_ff;
            rem_col_in = ge_col ? rem_col_ff - dsh_ff : rem_col_ff;
            q_row_in   = {q_row_ff[Q_W-2:0], ge_row};
            q_col_in   = {q_col_ff[Q_W-2:0], ge_col};
            dsh_in     = dsh_ff >> 1;
            step_in    = step_ff - 1'b1;
            if (step_ff == '0) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff    <= step_in;
      rem_row_ff <= rem_row_in;
      rem_col_ff <= rem_col_in;
      dsh_ff     <= dsh_in;
      q_row_ff   <= q_row_in;
      q_col_ff   <= q_col_in;
      hits_ff    <= hits_in;
      found_ff   <= found_in;
   end

endmodule
